[rtl/grld_pkg.sv]
// ----------------------------------------------------------------------------
// grld_pkg
// shared types and constants of the group run-length decoder
// ----------------------------------------------------------------------------
package grld_pkg;

	localparam int LINE_MAX   = 128;
	localparam int COUNT_BITS = 16;

	localparam int ADDR_W = $clog2(LINE_MAX);
	localparam int POS_W  = $clog2(LINE_MAX + 1);
	localparam int ACC_W  = COUNT_BITS + 4;

	localparam logic [COUNT_BITS-1:0] COUNT_SAT = {COUNT_BITS{1'b1}};

	localparam logic [7:0] CH_ZERO = 8'd48;
	localparam logic [7:0] CH_NINE = 8'd57;
	localparam logic [7:0] CH_NL   = 8'd10;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_code;
	} grld_req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       is_last;
	} grld_rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} grld_state_t;

	typedef enum logic [1:0] {
		SC_TOP,
		SC_COUNT,
		SC_SKIP
	} grld_scan_t;

endpackage

[rtl/grld_ram.sv]
// ----------------------------------------------------------------------------
// grld_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module grld_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 128,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/group_run_length_decoder.sv]
// ----------------------------------------------------------------------------
// group_run_length_decoder
// decodes one line of count-prefixed character groups from a line store
// ----------------------------------------------------------------------------
// A line is loaded one character per request (req_type load); a newline ends
// it and switches to emitting. Loads never raise busy; loads during emitting
// and ticks during loading are dropped without a result.
// In the emitting phase each tick request returns one decoded character with
// a one-cycle done strobe; the receiver cannot stall, so rsp must be captured
// in the cycle done is high. A tick raises busy while the walk reads the line
// store: one read for the returned character, plus one per count digit,
// one where a count ends or is found missing, one per skipped character of a
// dropped group plus one where that group ends, and one at the end of each
// pass over a repeated group. Done rises as busy falls. The walk is paced by
// the single line store read port, which delivers one character per cycle
// from a registered read. The closing newline is returned with is_last set,
// after which a new line can be loaded. Counts saturate at 2^COUNT_BITS-1,
// characters past LINE_MAX are dropped, and a group with no count or a zero
// count is skipped.
// ----------------------------------------------------------------------------
module group_run_length_decoder
	import grld_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  grld_req_t req,
	output logic      done,
	output grld_rsp_t rsp
);

	// control and walk state
	grld_state_t           state_q, state_d;
	grld_scan_t            scan_q, scan_d;
	logic                  emitting_q, emitting_d;
	logic [POS_W-1:0]      len_q, len_d;
	logic [POS_W-1:0]      rp_q, rp_d;
	logic [POS_W-1:0]      gs_q, gs_d;
	logic [COUNT_BITS-1:0] rl_q, rl_d;
	logic [COUNT_BITS-1:0] acc_q, acc_d;

	// result register
	logic      done_q, done_d;
	grld_rsp_t rsp_q, rsp_d;

	// line store port signals
	logic              ram_we;
	logic              ram_re;
	logic [7:0]        ram_rdata;

	// decode of the character under the read position
	logic             accepted;
	logic             in_line;
	logic             is_digit;
	logic             at_group;
	logic [ACC_W-1:0] acc_wide;
	logic [ACC_W-1:0] acc_sum;
	logic [COUNT_BITS-1:0] acc_sat;

	assign accepted = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign rsp      = rsp_q;

	// read data belongs to rp_q while evaluating; only written entries count
	assign in_line  = (rp_q < len_q);
	assign is_digit = (ram_rdata >= CH_ZERO) && (ram_rdata <= CH_NINE);
	assign at_group = in_line && !is_digit;

	// count step: acc * 10 + digit, saturating
	assign acc_wide = ACC_W'(acc_q);
	assign acc_sum  = (acc_wide << 3) + (acc_wide << 1) + ACC_W'(ram_rdata[3:0]);
	assign acc_sat  = (acc_sum > ACC_W'(COUNT_SAT)) ? COUNT_SAT
	                                                : acc_sum[COUNT_BITS-1:0];

	// loads never overlap reads: reads only happen while emitting
	assign ram_we = accepted && (req.req_type == REQ_LOAD) && !emitting_q &&
	                (req.char_code != CH_NL) && (len_q < POS_W'(LINE_MAX));
	assign ram_re = (state_d == ST_EVAL);

	grld_ram #(
		.WIDTH (8),
		.DEPTH (LINE_MAX)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (len_q[ADDR_W-1:0]),
		.wdata (req.char_code),
		.re    (ram_re),
		.raddr (rp_d[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= SC_TOP;
			emitting_q <= 1'b0;
			len_q      <= '0;
			rp_q       <= '0;
			gs_q       <= '0;
			rl_q       <= '0;
			acc_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			scan_q     <= scan_d;
			emitting_q <= emitting_d;
			len_q      <= len_d;
			rp_q       <= rp_d;
			gs_q       <= gs_d;
			rl_q       <= rl_d;
			acc_q      <= acc_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (done_d) begin
			rsp_q <= rsp_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		scan_d     = scan_q;
		emitting_d = emitting_q;
		len_d      = len_q;
		rp_d       = rp_q;
		gs_d       = gs_q;
		rl_d       = rl_q;
		acc_d      = acc_q;
		done_d     = 1'b0;
		rsp_d      = '{out_char: ram_rdata, is_last: 1'b0};

		unique case (state_q)
			ST_IDLE: begin
				if (accepted) begin
					if (req.req_type == REQ_LOAD) begin
						if (!emitting_q) begin
							if (req.char_code == CH_NL) begin
								// line complete, start the walk from the top
								emitting_d = 1'b1;
								rp_d       = '0;
								gs_d       = '0;
								rl_d       = '0;
								acc_d      = '0;
								scan_d     = SC_TOP;
							end else if (ram_we) begin
								len_d = len_q + POS_W'(1);
							end
						end
					end else if (emitting_q) begin
						// tick: fetch the character at the read position
						state_d = ST_EVAL;
					end
				end
			end

			ST_EVAL: begin
				priority if (rl_q != '0) begin
					// inside a repeated group
					if (at_group) begin
						rsp_d.out_char = ram_rdata;
						done_d         = 1'b1;
						rp_d           = rp_q + POS_W'(1);
						state_d        = ST_IDLE;
					end else begin
						// end of one repetition
						rl_d = rl_q - COUNT_BITS'(1);
						if (rl_q != COUNT_BITS'(1)) begin
							rp_d = gs_q;
						end
					end
				end else if (scan_q == SC_TOP && !in_line) begin
					// end of line: closing newline, back to loading
					rsp_d      = '{out_char: CH_NL, is_last: 1'b1};
					done_d     = 1'b1;
					emitting_d = 1'b0;
					len_d      = '0;
					rp_d       = '0;
					gs_d       = '0;
					acc_d      = '0;
					state_d    = ST_IDLE;
				end else if (scan_q != SC_SKIP) begin
					// count parse, top of a group counts as an empty count
					if (in_line && is_digit) begin
						acc_d  = acc_sat;
						rp_d   = rp_q + POS_W'(1);
						scan_d = SC_COUNT;
					end else begin
						gs_d  = rp_q;
						acc_d = '0;
						if (acc_q == '0 || !at_group) begin
							scan_d = SC_SKIP;
						end else begin
							rl_d   = acc_q;
							scan_d = SC_TOP;
						end
					end
				end else begin
					// dropped group: walk over its characters
					if (at_group) begin
						rp_d = rp_q + POS_W'(1);
					end else begin
						scan_d = SC_TOP;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// a result only follows an evaluation step
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_EVAL))
		else $error("result strobe without evaluation step");

	// the closing newline carries the newline code
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.is_last) |-> (rsp_q.out_char == CH_NL))
		else $error("last result is not a newline");

	// the line length is frozen while emitting
	assert property (@(posedge clk) disable iff (!arst_n)
		emitting_q |=> (!emitting_q || $stable(len_q)))
		else $error("line length changed while emitting");

	// the walk never passes the end of the line
	assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= len_q)
		else $error("read position beyond line length");

	// repeats and evaluation only exist in the emitting phase
	assert property (@(posedge clk) disable iff (!arst_n)
		(rl_q != '0 || state_q == ST_EVAL) |-> emitting_q)
		else $error("walk active outside emitting phase");

endmodule
